// File: rtl/msc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the mask stream compaction block.
// Used by msc_front, msc_queue, msc_back and mask_stream_compaction.
package msc_pkg;

  localparam int LANES      = 8;
  localparam int VALUE_W    = 64;
  localparam int COUNT_W    = 4;
  localparam int INDEX_BITS = 32;
  localparam int BASE_W     = 32;
  localparam int FLAGS_W    = 2;

  // Position of each flag within end_flags.
  localparam int FLAG_LAST = 0;
  localparam int FLAG_SAT  = 1;

  typedef enum logic [1:0] {
    EW_BYTE   = 2'd0,
    EW_HALF   = 2'd1,
    EW_WORD   = 2'd2,
    EW_DOUBLE = 2'd3
  } elem_width_t;

  typedef logic [LANES-1:0][VALUE_W-1:0] lane_vec_t;

  // One classified group as it travels from the front end to the back end.
  typedef struct packed {
    lane_vec_t            value;
    logic [LANES-1:0]     keep;
    logic [COUNT_W-1:0]   kept;
    logic [BASE_W-1:0]    base;
    logic [FLAGS_W-1:0]   flags;
  } msc_item_t;

  // One packed result as held in the output register.
  typedef struct packed {
    lane_vec_t            packed_value;
    logic [COUNT_W-1:0]   kept;
    logic [BASE_W-1:0]    base;
    logic [FLAGS_W-1:0]   flags;
  } msc_result_t;

  function automatic logic [VALUE_W-1:0] width_mask(input elem_width_t code);
    logic [VALUE_W-1:0] m;
    m = '1;
    unique case (code)
      EW_BYTE:   m = VALUE_W'(8'hFF);
      EW_HALF:   m = VALUE_W'(16'hFFFF);
      EW_WORD:   m = VALUE_W'(32'hFFFF_FFFF);
      EW_DOUBLE: m = '1;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/msc_front.sv
`timescale 1ns / 1ps
// Front end: accepts groups, trims lanes and values, counts kept lanes and
// keeps the running output index. Depends on msc_pkg.
module msc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  msc_pkg::elem_width_t width_code,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msc_pkg::lane_vec_t   lane_value,
  input  logic [7:0]           keep_mask,
  input  logic [3:0]           lane_count,
  input  logic                 last_group,
  output logic                 push_valid,
  input  logic                 push_ready,
  output msc_pkg::msc_item_t   push_item
);
  import msc_pkg::*;

  localparam int KSF_W = INDEX_BITS + 1;
  localparam int SUM_W = INDEX_BITS + 2;
  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(1) << INDEX_BITS;
  localparam logic [KSF_W-1:0] KSF_LIMIT = KSF_W'(1) << INDEX_BITS;

  logic [KSF_W-1:0]      kept_so_far;
  logic [KSF_W-1:0]      kept_so_far_next;
  logic [LANES-1:0]      eff_keep;
  logic [COUNT_W-1:0]    kept;
  logic [VALUE_W-1:0]    vmask;
  logic [SUM_W-1:0]      sum;
  logic                  over;
  logic [INDEX_BITS-1:0] base_clip;
  logic                  accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign vmask      = width_mask(width_code);

  always_comb begin
    kept = '0;
    for (int i = 0; i < LANES; i++) begin
      eff_keep[i] = keep_mask[i] && (lane_count > COUNT_W'(i));
      kept        = kept + COUNT_W'(eff_keep[i]);
    end
  end

  assign sum       = SUM_W'(kept_so_far) + SUM_W'(kept);
  assign over      = sum > SUM_LIMIT;
  // The count can reach the limit itself; the index shown stops one below.
  assign base_clip = kept_so_far[INDEX_BITS] ? '1 : kept_so_far[INDEX_BITS-1:0];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      push_item.value[i] = lane_value[i] & vmask;
    end
    push_item.keep            = eff_keep;
    push_item.kept            = kept;
    push_item.base            = BASE_W'(base_clip);
    push_item.flags           = '0;
    push_item.flags[FLAG_LAST] = last_group;
    push_item.flags[FLAG_SAT]  = over;
  end

  always_comb begin
    if (last_group) begin
      kept_so_far_next = '0;
    end else if (over) begin
      kept_so_far_next = KSF_LIMIT;
    end else begin
      kept_so_far_next = sum[KSF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_so_far <= '0;
    end else if (accept) begin
      kept_so_far <= kept_so_far_next;
    end
  end

endmodule

// File: rtl/msc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of classified groups between front and back end.
// Depends on msc_pkg.
module msc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  msc_pkg::msc_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output msc_pkg::msc_item_t pop_item
);
  import msc_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  msc_item_t         entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != CNT_W'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/msc_back.sv
`timescale 1ns / 1ps
// Back end: packs the kept lanes of a group low and holds the result in the
// output register. Depends on msc_pkg.
module msc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  msc_pkg::msc_item_t  pop_item,
  output logic                out_valid,
  input  logic                out_ready,
  output msc_pkg::msc_result_t result
);
  import msc_pkg::*;

  logic [LANES-1:0][COUNT_W-1:0] pos;
  lane_vec_t                     packed_next;
  logic                          load;

  assign pop_ready = !out_valid || out_ready;
  assign load      = pop_valid && pop_ready;

  // Destination of each lane is the number of kept lanes below it.
  always_comb begin
    pos[0] = '0;
    for (int i = 1; i < LANES; i++) begin
      pos[i] = pos[i-1] + COUNT_W'(pop_item.keep[i-1]);
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      packed_next[k] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (pop_item.keep[i] && pos[i] == COUNT_W'(k)) begin
          packed_next[k] = packed_next[k] | pop_item.value[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.packed_value <= packed_next;
      result.kept         <= pop_item.kept;
      result.base         <= pop_item.base;
      result.flags        <= pop_item.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/mask_stream_compaction.sv
`timescale 1ns / 1ps
// Top level of the mask stream compaction block: configuration register and
// the front end, queue and back end. Depends on msc_pkg and its submodules.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  input     | in_valid / in_ready    | lane_value0..7, keep_mask, lane_count,
//            |                        | last_group
//  output    | out_valid / out_ready  | packed_value0..7, kept_count,
//            |                        | base_index, end_flags
//  config    | cfg_write (no wait)    | cfg_data -> element width code
//
// One group is accepted per cycle when the output side keeps up; a group's
// result passes through the queue and then the output register. The running
// index update is one add in the front end. Reset clears the running index,
// the queue and the output valid, and sets the element width to eight bytes.
// The two-entry queue lets the front end keep accepting while the output side
// stalls, until the queue is full, and in_ready comes from the queue fill
// alone, never from out_ready.
module mask_stream_compaction (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] lane_value0,
  input  logic [63:0] lane_value1,
  input  logic [63:0] lane_value2,
  input  logic [63:0] lane_value3,
  input  logic [63:0] lane_value4,
  input  logic [63:0] lane_value5,
  input  logic [63:0] lane_value6,
  input  logic [63:0] lane_value7,
  input  logic [7:0]  keep_mask,
  input  logic [3:0]  lane_count,
  input  logic        last_group,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] packed_value0,
  output logic [63:0] packed_value1,
  output logic [63:0] packed_value2,
  output logic [63:0] packed_value3,
  output logic [63:0] packed_value4,
  output logic [63:0] packed_value5,
  output logic [63:0] packed_value6,
  output logic [63:0] packed_value7,
  output logic [3:0]  kept_count,
  output logic [31:0] base_index,
  output logic [1:0]  end_flags
);
  import msc_pkg::*;

  elem_width_t width_code;
  lane_vec_t   lane_value;
  logic        push_valid;
  logic        push_ready;
  msc_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  msc_item_t   pop_item;
  msc_result_t result;

  // The user must change the width code only while the block is idle, so groups
  // in flight never see a mix of widths; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_code <= EW_DOUBLE;
    end else if (cfg_write) begin
      width_code <= elem_width_t'(cfg_data);
    end
  end

  assign lane_value[0] = lane_value0;
  assign lane_value[1] = lane_value1;
  assign lane_value[2] = lane_value2;
  assign lane_value[3] = lane_value3;
  assign lane_value[4] = lane_value4;
  assign lane_value[5] = lane_value5;
  assign lane_value[6] = lane_value6;
  assign lane_value[7] = lane_value7;

  msc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .width_code (width_code),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .lane_value (lane_value),
    .keep_mask  (keep_mask),
    .lane_count (lane_count),
    .last_group (last_group),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  msc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  msc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign packed_value0 = result.packed_value[0];
  assign packed_value1 = result.packed_value[1];
  assign packed_value2 = result.packed_value[2];
  assign packed_value3 = result.packed_value[3];
  assign packed_value4 = result.packed_value[4];
  assign packed_value5 = result.packed_value[5];
  assign packed_value6 = result.packed_value[6];
  assign packed_value7 = result.packed_value[7];
  assign kept_count    = result.kept;
  assign base_index    = result.base;
  assign end_flags     = result.flags;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for mask_stream_compaction: directed and random groups,
// with a running-index predictor and random stalls on both channels.
// Depends on msc_pkg and the mask_stream_compaction RTL.
module testbench;
  import msc_pkg::*;

  // One input group as the driver offers it.
  typedef struct packed {
    logic [7:0][63:0] value;
    logic [7:0]       keep;
    logic [3:0]       count;
    logic             last;
  } group_t;

  localparam logic [32:0] INDEX_LIMIT = 33'h1_0000_0000;
  localparam logic [32:0] INDEX_MAX   = 33'h0_FFFF_FFFF;
  localparam int          STALL_LIMIT = 500;
  localparam int          HOLD_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  group_t      offered = '0;
  wire         in_ready;
  wire         out_valid;
  wire  [7:0][63:0] out_lanes;
  wire  [3:0]  kept_count;
  wire  [31:0] base_index;
  wire  [1:0]  end_flags;

  // Predictor state: the element width in force and the running kept count.
  elem_width_t width_now = EW_DOUBLE;
  logic [32:0] running_kept = '0;

  group_t      pending_groups[$];
  msc_result_t expected_packs[$];

  // Bookkeeping shared between the processes; each but error_count has a single writer.
  bit group_fired = 1'b0;
  int groups_queued = 0;
  int results_seen = 0;
  int error_count = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 16;

  mask_stream_compaction DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .lane_value0   (offered.value[0]),
    .lane_value1   (offered.value[1]),
    .lane_value2   (offered.value[2]),
    .lane_value3   (offered.value[3]),
    .lane_value4   (offered.value[4]),
    .lane_value5   (offered.value[5]),
    .lane_value6   (offered.value[6]),
    .lane_value7   (offered.value[7]),
    .keep_mask     (offered.keep),
    .lane_count    (offered.count),
    .last_group    (offered.last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packed_value0 (out_lanes[0]),
    .packed_value1 (out_lanes[1]),
    .packed_value2 (out_lanes[2]),
    .packed_value3 (out_lanes[3]),
    .packed_value4 (out_lanes[4]),
    .packed_value5 (out_lanes[5]),
    .packed_value6 (out_lanes[6]),
    .packed_value7 (out_lanes[7]),
    .kept_count    (kept_count),
    .base_index    (base_index),
    .end_flags     (end_flags)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bits of a lane that survive at the given element width.
  function automatic logic [63:0] lane_mask(input elem_width_t w);
    int bits;
    bits = 8 << int'(w);
    if (w == EW_DOUBLE) return '1;
    return ~({64{1'b1}} << bits);
  endfunction

  // Packs the kept lanes of one group, works out its base index and flags,
  // and advances the running kept count.
  function automatic msc_result_t compact_group(input group_t g);
    msc_result_t r;
    logic [63:0] vmask;
    logic [32:0] total;
    int valid_lanes;
    int n;
    r = '0;
    vmask = lane_mask(width_now);
    // Counts above the lane total are clipped; a count of zero keeps nothing.
    valid_lanes = (g.count > LANES) ? LANES : int'(g.count);
    n = 0;
    for (int i = 0; i < valid_lanes; i++) begin
      if (g.keep[i]) begin
        r.packed_value[n] = g.value[i] & vmask;
        n++;
      end
    end
    total = running_kept + 33'(n);
    r.kept = COUNT_W'(n);
    r.base = (running_kept > INDEX_MAX) ? INDEX_MAX[31:0] : running_kept[31:0];
    r.flags[FLAG_LAST] = g.last;
    r.flags[FLAG_SAT] = (total > INDEX_LIMIT);
    // The result is formed first; only then does a last group clear the count.
    if (g.last) begin
      running_kept = '0;
    end else begin
      running_kept = (total > INDEX_LIMIT) ? INDEX_LIMIT : total;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Sampling happens at the rising edge, before the block's own updates land,
  // so each transaction is seen with the values that were present at the edge.
  always @(posedge clk) begin : monitor
    msc_result_t want;
    int stalled;
    group_fired = !rst && in_valid && in_ready;
    if (group_fired) begin
      expected_packs.push_back(compact_group(offered));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_packs.size() == 0) begin
        $error("result transaction with no expectation waiting");
        error_count++;
      end else begin
        want = expected_packs.pop_front();
        for (int i = 0; i < LANES; i++) begin
          check_field($sformatf("packed_value%0d", i), want.packed_value[i], out_lanes[i]);
        end
        check_field("kept_count", 64'(want.kept), 64'(kept_count));
        check_field("base_index", 64'(want.base), 64'(base_index));
        check_field("end_flags", 64'(want.flags), 64'(end_flags));
      end
      results_seen++;
      stalled = 0;
    end else if (group_fired) begin
      stalled = 0;
    end else begin
      stalled++;
    end
    // Watchdog: too long with no transaction on either channel.
    if (stalled >= STALL_LIMIT) begin
      $display("mask_stream_compaction test failed");
      $finish;
    end
  end

  // Sender: offers the next pending group whenever the channel is free,
  // idling now and then. Valid stays up until the transaction completes.
  always @(negedge clk) begin : driver
    group_t g;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || group_fired) begin
      if (pending_groups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        g = pending_groups.pop_front();
        offered <= g;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus two long hold-offs in mid-phase so
  // that the queue fills and the block has to drop in_ready.
  always @(negedge clk) begin : receiver
    int hold_left;
    int hold_stage;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_stage = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_stage < 2 && results_seen >= (hold_stage == 0 ? 300 : 1100)) begin
      hold_stage++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'h0101_0101_0101_0101;
      3: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_keep();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic group_t make_group(input logic [7:0] keep, input logic [3:0] count,
                                        input logic last);
    group_t g;
    for (int i = 0; i < LANES; i++) g.value[i] = pick_value();
    g.keep = keep;
    g.count = count;
    g.last = last;
    return g;
  endfunction

  task automatic offer(input group_t g);
    pending_groups.push_back(g);
    groups_queued++;
  endtask

  // Mostly whole arrays (full groups, then a tail group marked last), with
  // some stray groups of any count, including zero and counts above eight.
  task automatic queue_random(input int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 15) begin
        offer(make_group(pick_keep(), 4'($urandom_range(15)), 1'($urandom_range(1))));
        added++;
      end else begin
        len = $urandom_range(1, 10);
        for (int j = 0; j < len; j++) begin
          if (j == len - 1) begin
            offer(make_group(pick_keep(), 4'($urandom_range(1, 8)), 1'b1));
          end else begin
            offer(make_group(pick_keep(), 4'd8, 1'b0));
          end
        end
        added += len;
      end
    end
  endtask

  // Pause the sender until every queued group has come back as a result.
  task automatic wait_idle();
    while (results_seen != groups_queued) @(negedge clk);
  endtask

  task automatic set_width(input elem_width_t w);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= w;
    width_now = w;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    group_t g;
    elem_width_t phase_width[8];
    phase_width = '{EW_BYTE, EW_HALF, EW_WORD, EW_DOUBLE, EW_BYTE, EW_WORD, EW_DOUBLE,
                    EW_HALF};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed groups at the reset width of eight bytes.
    g = make_group(8'hFF, 4'd8, 1'b0);
    g.value = '1;
    offer(g);
    g.value = '0;
    offer(g);
    g.value = {8{64'h0101_0101_0101_0101}};
    offer(g);
    offer(make_group(8'h00, 4'd8, 1'b0));
    offer(make_group(8'h55, 4'd8, 1'b0));
    offer(make_group(8'hAA, 4'd8, 1'b0));
    offer(make_group(8'h80, 4'd8, 1'b0));
    offer(make_group(8'h01, 4'd8, 1'b0));
    // A lane count of zero keeps nothing whatever the mask says.
    offer(make_group(8'hFF, 4'd0, 1'b0));
    // Counts above the lane total are taken as a full group.
    offer(make_group(8'hFF, 4'd15, 1'b0));
    offer(make_group(8'hF0, 4'd9, 1'b0));
    // Mask bits beyond the lane count are ignored.
    offer(make_group(8'hFF, 4'd3, 1'b0));
    offer(make_group(8'hFE, 4'd1, 1'b0));
    offer(make_group(8'hFF, 4'd8, 1'b1));
    offer(make_group(8'h00, 4'd5, 1'b1));
    offer(make_group(8'hFF, 4'd7, 1'b1));
    wait_idle();

    // Random phases, each at the element width set for it; the fifth runs without idling.
    for (int p = 0; p < 8; p++) begin
      set_width(phase_width[p]);
      send_idle_pct = (p == 4) ? 0 : 16;
      recv_idle_pct = (p == 4) ? 0 : 16;
      queue_random(192);
      wait_idle();
    end

    // Give the block time to show any stray result before the verdict.
    repeat (10) @(negedge clk);
    if (expected_packs.size() != 0) begin
      $error("%0d expected results never arrived", expected_packs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("mask_stream_compaction test passed");
    end else begin
      $display("mask_stream_compaction test failed");
    end
    $finish;
  end

endmodule
